// ----- hw/rtl/btlp_pkg.sv -----
`timescale 1ns / 1ps
// Package for the button tap / long-press classifier.
// Holds the action codes, the classifier state type and field widths; no dependencies.
package btlp_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned CfgW  = 16;
	localparam int unsigned CntW  = 2;

	typedef enum logic [2:0] {
		ACT_NONE   = 3'd0,
		ACT_SINGLE = 3'd1,
		ACT_DOUBLE = 3'd2,
		ACT_TRIPLE = 3'd3,
		ACT_LONG   = 3'd4
	} action_t;

	// Configuration register indexes
	typedef enum logic {
		CFG_TAP_WINDOW = 1'b0,
		CFG_LONG_PRESS = 1'b1
	} cfg_idx_t;

	localparam logic [CfgW-1:0] TapWindowRst = 16'd400;
	localparam logic [CfgW-1:0] LongPressRst = 16'd800;

	typedef struct packed {
		logic             held;
		logic [TimeW-1:0] press_start_time;
		logic [TimeW-1:0] last_release_time;
		logic [CntW-1:0]  tap_counter;
		logic             long_reported;
	} btlp_state_t;

endpackage

// ----- hw/rtl/btlp_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the poll items and the action items.
// Depends on btlp_pkg.
interface btlp_in_if;
	logic        valid;
	logic        ready;
	logic        button_down;
	logic [31:0] now_ms;

	modport source (output valid, output button_down, output now_ms, input ready);
	modport sink   (input valid, input button_down, input now_ms, output ready);
endinterface

interface btlp_out_if;
	logic                  valid;
	logic                  ready;
	btlp_pkg::action_t     action;

	modport source (output valid, output action, input ready);
	modport sink   (input valid, input action, output ready);
endinterface

// ----- hw/rtl/btlp_step.sv -----
`timescale 1ns / 1ps
// Next-state and action logic for one poll of the classifier.
// Depends on btlp_pkg.
module btlp_step (
	input  btlp_pkg::btlp_state_t               state,
	input  logic                                button_down,
	input  logic [btlp_pkg::TimeW-1:0]          now_ms,
	input  logic [btlp_pkg::CfgW-1:0]           tap_window_ms,
	input  logic [btlp_pkg::CfgW-1:0]           long_press_ms,
	output btlp_pkg::btlp_state_t               state_next,
	output btlp_pkg::action_t                   action
);
	import btlp_pkg::*;

	logic [TimeW-1:0] since_release;
	logic [TimeW-1:0] since_press;
	logic [TimeW-1:0] win_ext;
	logic [TimeW-1:0] long_ext;
	logic             have_release;
	logic             single_expired;
	logic [CntW-1:0]  cnt_tmp;

	assign since_release  = now_ms - state.last_release_time;
	assign since_press    = now_ms - state.press_start_time;
	assign win_ext        = {{(TimeW-CfgW){1'b0}}, tap_window_ms};
	assign long_ext       = {{(TimeW-CfgW){1'b0}}, long_press_ms};
	assign have_release   = (state.last_release_time != '0);
	assign single_expired = (state.tap_counter == CntW'(1)) && have_release && !state.held &&
		(since_release >= win_ext);

	always_comb begin
		state_next = state;
		action     = ACT_NONE;
		cnt_tmp    = state.tap_counter;
		if (single_expired) begin
			// lone tap window ran out: report and do nothing else this poll
			state_next.tap_counter       = '0;
			state_next.last_release_time = '0;
			action                       = ACT_SINGLE;
		end else if (button_down && !state.held) begin
			state_next.held             = 1'b1;
			state_next.press_start_time = now_ms;
			state_next.long_reported    = 1'b0;
		end else if (!button_down && state.held) begin
			state_next.held = 1'b0;
			if (state.long_reported) begin
				cnt_tmp = '0;
			end else if (have_release && (since_release < win_ext)) begin
				cnt_tmp = state.tap_counter + CntW'(1);
			end else begin
				cnt_tmp = CntW'(1);
			end
			state_next.tap_counter       = cnt_tmp;
			state_next.last_release_time = now_ms;
			if (cnt_tmp == CntW'(3)) begin
				action                       = ACT_TRIPLE;
				state_next.tap_counter       = '0;
				state_next.last_release_time = '0;
			end else if (cnt_tmp == CntW'(2)) begin
				action                       = ACT_DOUBLE;
				state_next.tap_counter       = '0;
				state_next.last_release_time = '0;
			end
		end else if (button_down && state.held && !state.long_reported &&
			(since_press >= long_ext)) begin
			state_next.long_reported     = 1'b1;
			state_next.tap_counter       = '0;
			state_next.last_release_time = '0;
			action                       = ACT_LONG;
		end
	end

endmodule

// ----- hw/rtl/button_tap_long_press_classifier.sv -----
`timescale 1ns / 1ps
// Top level of the button tap / long-press classifier.
// Depends on btlp_pkg, btlp_if (btlp_in_if, btlp_out_if) and btlp_step.
//
// Each poll item (button level plus a free-running millisecond timestamp)
// yields exactly one action item: none, single, double, triple or long press.
// A poll is captured in an input register, classified combinationally against
// the stored button state, and the action is registered in an output register
// when the input stage advances. The block takes one poll per cycle as long
// as the output side keeps taking actions; the single classification step
// between the input and output registers sets that rate. Configuration (tap
// window and long-press threshold, 16-bit milliseconds) must be written by the
// user through the plain write port while no poll is in flight; the block
// itself does not enforce this.
module button_tap_long_press_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  btlp_pkg::cfg_idx_t             cfg_index,
	input  logic [btlp_pkg::CfgW-1:0]      cfg_data,
	btlp_in_if.sink                        in_ch,
	btlp_out_if.source                     out_ch
);
	import btlp_pkg::*;

	// configuration registers
	logic [CfgW-1:0] tap_window_q;
	logic [CfgW-1:0] long_press_q;

	// input stage
	logic             valid_s1;
	logic             down_s1;
	logic [TimeW-1:0] now_s1;

	// classifier state and output register
	btlp_state_t state_q;
	btlp_state_t state_next;
	action_t     action_next;
	action_t     action_q;
	logic        out_valid_q;

	logic advance;

	// Move the input stage forward whenever the output register is free or drains.
	assign advance      = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = !valid_s1 || advance;
	assign out_ch.valid = out_valid_q;
	assign out_ch.action = action_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_window_q <= TapWindowRst;
			long_press_q <= LongPressRst;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TAP_WINDOW: tap_window_q <= cfg_data;
				CFG_LONG_PRESS: long_press_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold the captured poll until the classifier stage can take it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			down_s1 <= in_ch.button_down;
			now_s1  <= in_ch.now_ms;
		end
	end

	btlp_step u_step (
		.state         (state_q),
		.button_down   (down_s1),
		.now_ms        (now_s1),
		.tap_window_ms (tap_window_q),
		.long_press_ms (long_press_q),
		.state_next    (state_next),
		.action        (action_next)
	);

	// Commit state and the action only when the poll actually advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			action_q <= action_next;
		end
	end

endmodule

// ----- tb/sv/button_tap_long_press_classifier_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for button_tap_long_press_classifier.
// Depends on btlp_pkg, btlp_if and the classifier top level; drives polls, checks actions
// against an in-bench predictor of the tap / double / triple / long-press classification.
module button_tap_long_press_classifier_test;
	import btlp_pkg::*;

	localparam int unsigned CycleLimit = 600000;
	localparam int unsigned PhaseItems = 150;

	typedef enum logic {
		ROW_POLL,
		ROW_WRITE
	} row_kind_t;

	// One row of the directed plan: a poll or a register write.
	typedef struct {
		row_kind_t        kind;
		logic             down;
		logic [TimeW-1:0] now;
		cfg_idx_t         idx;
		logic [CfgW-1:0]  data;
		bit               typed;
		action_t          want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CfgW-1:0] cfg_data;

	btlp_in_if  poll_ch ();
	btlp_out_if action_ch ();

	button_tap_long_press_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (poll_ch),
		.out_ch    (action_ch)
	);

	// Predictor copy of the classifier state and its two thresholds.
	logic             p_held;
	logic [TimeW-1:0] p_press;
	logic [TimeW-1:0] p_release;
	logic [CntW-1:0]  p_taps;
	logic             p_long;
	logic [CfgW-1:0]  p_window;
	logic [CfgW-1:0]  p_long_ms;

	action_t     pending_actions [$];
	plan_row_t   plan [$];
	int unsigned fails = 0;
	int unsigned cycles = 0;
	int unsigned phase_polls;
	bit          calm;
	logic [TimeW-1:0] t;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort the run if the block stops making progress.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("button_tap_long_press_classifier_test failed");
			$finish;
		end
	end

	// Classify one poll the way the block does; update the predictor state.
	function automatic action_t classify_poll(input logic down, input logic [TimeW-1:0] now);
		logic [TimeW-1:0] since_release;
		action_t act;
		since_release = now - p_release;
		act = ACT_NONE;
		// A lone tap whose window ran out claims the whole poll.
		if (p_taps == 2'd1 && p_release != '0 && !p_held &&
		    since_release >= {16'd0, p_window}) begin
			p_taps = '0;
			p_release = '0;
			return ACT_SINGLE;
		end
		if (down && !p_held) begin
			p_held = 1'b1;
			p_press = now;
			p_long = 1'b0;
		end else if (!down && p_held) begin
			p_held = 1'b0;
			if (p_long) begin
				// Release after a long press: drop the count, then still note the time.
				p_taps = '0;
				p_release = '0;
			end else if (p_release != '0 && since_release < {16'd0, p_window}) begin
				p_taps = p_taps + 2'd1;
			end else begin
				p_taps = 2'd1;
			end
			p_release = now;
			if (p_taps == 2'd3) begin
				act = ACT_TRIPLE;
				p_taps = '0;
				p_release = '0;
			end else if (p_taps == 2'd2) begin
				act = ACT_DOUBLE;
				p_taps = '0;
				p_release = '0;
			end
		end else if (down && p_held && !p_long && (now - p_press) >= {16'd0, p_long_ms}) begin
			p_long = 1'b1;
			p_taps = '0;
			p_release = '0;
			act = ACT_LONG;
		end
		return act;
	endfunction

	// Idle length: mostly none, some short, a few long; none in a calm phase.
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Time step between polls, scaled to the current thresholds.
	function automatic logic [TimeW-1:0] hop_ms();
		logic [TimeW-1:0] win;
		logic [TimeW-1:0] lp;
		win = {16'd0, p_window};
		lp = {16'd0, p_long_ms};
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3);
			1: return $urandom_range(1, (win > 1) ? win - 1 : 1);
			2: return $urandom_range((win > 0) ? win - 1 : 0, win + 1);
			3: return $urandom_range((lp > 0) ? lp - 1 : 0, lp + 1);
			4: return $urandom_range(0, 2 * lp);
			default: return $urandom_range(0, 2 * win);
		endcase
	endfunction

	function automatic plan_row_t poll_row(input logic down, input logic [TimeW-1:0] now,
	                                       input bit typed, input action_t want);
		plan_row_t r;
		r.kind = ROW_POLL;
		r.down = down;
		r.now = now;
		r.idx = CFG_TAP_WINDOW;
		r.data = '0;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic plan_row_t write_row(input cfg_idx_t idx, input logic [CfgW-1:0] data);
		plan_row_t r;
		r = poll_row(1'b0, '0, 1'b0, ACT_NONE);
		r.kind = ROW_WRITE;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	// Offer one poll item, hold it until accepted, then log its expected action.
	task automatic send_poll(input logic down, input logic [TimeW-1:0] now,
	                         input bit typed, input action_t want);
		int unsigned gap;
		action_t predicted;
		gap = idle_len();
		if (gap > 0) begin
			poll_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		poll_ch.valid <= 1'b1;
		poll_ch.button_down <= down;
		poll_ch.now_ms <= now;
		do
			@(posedge clk);
		while (!poll_ch.ready);
		predicted = classify_poll(down, now);
		pending_actions.push_back(typed ? want : predicted);
		phase_polls++;
	endtask

	// Drop valid and wait until every expected action has come back.
	task automatic drain();
		poll_ch.valid <= 1'b0;
		while (pending_actions.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == CFG_TAP_WINDOW)
			p_window = data;
		else
			p_long_ms = data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Action sink: check each accepted action, stall at random in between.
	initial begin
		int unsigned stall_left;
		action_t want;
		stall_left = 0;
		action_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (action_ch.valid && action_ch.ready) begin
				if (pending_actions.size() == 0) begin
					$error("action: unexpected item, got %0d", action_ch.action);
					fails++;
				end else begin
					want = pending_actions.pop_front();
					if (action_ch.action !== want) begin
						$error("action: expected %0d, got %0d", want, action_ch.action);
						fails++;
					end
				end
			end
			if (stall_left > 0) begin
				action_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				action_ch.ready <= 1'b1;
				stall_left = idle_len();
			end
		end
	end

	initial begin
		int unsigned kind;
		int unsigned n;
		logic [CfgW-1:0] win_set [8];
		logic [CfgW-1:0] lp_set [8];

		calm = 1'b0;
		phase_polls = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_TAP_WINDOW;
		cfg_data <= '0;
		poll_ch.valid <= 1'b0;
		poll_ch.button_down <= 1'b0;
		poll_ch.now_ms <= '0;

		p_held = 1'b0;
		p_press = '0;
		p_release = '0;
		p_taps = '0;
		p_long = 1'b0;
		p_window = TapWindowRst;
		p_long_ms = LongPressRst;

		// Directed plan, starting from the reset thresholds 400 / 800.
		plan.push_back(poll_row(1'b0, 32'd0, 1'b1, ACT_NONE));
		plan.push_back(poll_row(1'b1, 32'd100, 1'b1, ACT_NONE));
		plan.push_back(poll_row(1'b0, 32'd150, 1'b1, ACT_NONE));
		plan.push_back(poll_row(1'b1, 32'd300, 1'b1, ACT_NONE));
		plan.push_back(poll_row(1'b0, 32'd350, 1'b1, ACT_DOUBLE));
		plan.push_back(poll_row(1'b1, 32'd1000, 1'b1, ACT_NONE));
		plan.push_back(poll_row(1'b1, 32'd1800, 1'b1, ACT_LONG));
		plan.push_back(poll_row(1'b1, 32'd5000, 1'b1, ACT_NONE));
		// Release after the long press, then a tap that counts from zero.
		plan.push_back(poll_row(1'b0, 32'd5100, 1'b0, ACT_NONE));
		plan.push_back(poll_row(1'b1, 32'd5200, 1'b0, ACT_NONE));
		plan.push_back(poll_row(1'b0, 32'd5250, 1'b0, ACT_NONE));
		plan.push_back(poll_row(1'b0, 32'd5650, 1'b0, ACT_NONE));
		// Release exactly at time zero reads as no release at all.
		plan.push_back(poll_row(1'b1, 32'hFFFF_FF00, 1'b0, ACT_NONE));
		plan.push_back(poll_row(1'b0, 32'h0000_0000, 1'b0, ACT_NONE));
		plan.push_back(poll_row(1'b1, 32'd100, 1'b0, ACT_NONE));
		plan.push_back(poll_row(1'b0, 32'd150, 1'b0, ACT_NONE));
		// Window expiry swallows the press on the same poll; next poll takes it.
		plan.push_back(poll_row(1'b1, 32'hFFFF_FFFF, 1'b0, ACT_NONE));
		plan.push_back(poll_row(1'b1, 32'hFFFF_FFFF, 1'b0, ACT_NONE));
		// Zero window and zero long threshold.
		plan.push_back(write_row(CFG_TAP_WINDOW, 16'd0));
		plan.push_back(write_row(CFG_LONG_PRESS, 16'd0));
		plan.push_back(poll_row(1'b0, 32'h8000_0000, 1'b0, ACT_NONE));
		plan.push_back(poll_row(1'b0, 32'h8000_0000, 1'b0, ACT_NONE));
		plan.push_back(poll_row(1'b1, 32'h5555_5555, 1'b0, ACT_NONE));
		plan.push_back(poll_row(1'b1, 32'h5555_5555, 1'b0, ACT_NONE));
		plan.push_back(poll_row(1'b0, 32'hAAAA_AAAA, 1'b0, ACT_NONE));

		// Threshold pairs for the random phases, extremes first.
		win_set = '{16'd1, 16'd65535, 16'd1, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd400};
		lp_set  = '{16'd1, 16'd65535, 16'd65535, 16'd1, 16'd0, 16'd0, 16'd0, 16'd800};
		for (int i = 4; i < 7; i++) begin
			win_set[i] = CfgW'($urandom_range(1, 65535));
			lp_set[i] = CfgW'($urandom_range(1, 65535));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed plan; drain before any register write.
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_WRITE) begin
				drain();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				send_poll(plan[i].down, plan[i].now, plan[i].typed, plan[i].want);
			end
		end

		// Random phases: mostly press / hold / release sequences, some noise.
		for (int ph = 0; ph < 8; ph++) begin
			drain();
			write_reg(CFG_TAP_WINDOW, win_set[ph]);
			write_reg(CFG_LONG_PRESS, lp_set[ph]);
			calm = ($urandom_range(0, 3) == 0);
			phase_polls = 0;
			t = $urandom;
			while (phase_polls < PhaseItems) begin
				kind = $urandom_range(0, 9);
				if (kind <= 6) begin
					t += hop_ms();
					send_poll(1'b1, t, 1'b0, ACT_NONE);
					n = $urandom_range(0, 3);
					repeat (n) begin
						t += hop_ms();
						send_poll(1'b1, t, 1'b0, ACT_NONE);
					end
					t += hop_ms();
					send_poll(1'b0, t, 1'b0, ACT_NONE);
					n = $urandom_range(0, 3);
					repeat (n) begin
						t += hop_ms();
						send_poll(1'b0, t, 1'b0, ACT_NONE);
					end
				end else if (kind == 7) begin
					// Jump anywhere in time with a random level.
					t = $urandom;
					send_poll(1'($urandom_range(0, 1)), t, 1'b0, ACT_NONE);
				end else if (kind == 8) begin
					// Press just before the wrap and release right on zero.
					t = 32'd0 - $urandom_range(1, {16'd0, p_long_ms} + 5);
					send_poll(1'b1, t, 1'b0, ACT_NONE);
					t = '0;
					send_poll(1'b0, t, 1'b0, ACT_NONE);
				end else begin
					// Repeat one timestamp with random levels.
					n = $urandom_range(1, 4);
					repeat (n) send_poll(1'($urandom_range(0, 1)), t, 1'b0, ACT_NONE);
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (fails == 0)
			$display("button_tap_long_press_classifier_test passed");
		else
			$display("button_tap_long_press_classifier_test failed");
		$finish;
	end

endmodule
